// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum unit
// Holds the cell control bundle and the configuration register width.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  // Width of the window_size configuration register
  localparam int unsigned CFG_W = 7;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;  // a sample request was taken: every cell takes the max of its neighbor and the new sample
    logic clear;  // sequence ends or window is reprogrammed: drop all history
  } swm_ctrl_t;

endpackage

`default_nettype wire

// ===== design/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one stage of the running-maximum chain
// Cell i holds the maximum of the last i+1 samples. On a shift it takes the
// maximum of its left neighbor and the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire swm_ctrl_t              ctrl,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] prev_max_i,
  input  wire logic                   prev_valid_i,
  output logic      [SAMPLE_BITS-1:0] max_o,
  output logic                        valid_o
);

  logic [SAMPLE_BITS-1:0] max_r;
  logic [SAMPLE_BITS-1:0] max_nxt;
  logic                   valid_r;

  // An empty neighbor counts as minus infinity
  always_comb begin
    if (prev_valid_i && ($signed(prev_max_i) > $signed(sample_i))) begin
      max_nxt = prev_max_i;
    end else begin
      max_nxt = sample_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      max_r <= max_nxt;
    end
  end

  assign max_o   = max_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

// ===== design/sliding_window_maximum_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit: streaming sliding window maximum
// Emits the maximum of the last window_size signed samples, using a chain
// of running-maximum cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed sample per request, tlast marks the final sample of
//           a sequence.
//   out_* : window_max in tdata, tlast echoes the end mark, tuser flags a
//           sequence that ended before the window filled (the maximum of the
//           samples seen is given then).
//   cfg_* : writes window_size (0 reads as 1, above WINDOW_MAX saturates).
//           A write also restarts the sequence. Write only while idle.
// No result is sent while the window is still filling, unless tlast ends it.
// Output: a result is registered and is on out_* in the cycle after its sample is taken.
// Throughput: one sample per cycle while in_tready is high; the chain of WINDOW_MAX cells updates
//   all partial maxima in parallel, each cell one compare.
// Stall: a single output register holds the result; in_tready stays high
//   while that register is empty or being drained in the same cycle, and
//   drops while a window write is offered.
// Reset: synchronous, active low; window_size returns to 1 and the sequence
//   state (cell valid bits, fill count) is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, rest zero padding
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,
  input  wire logic                                    in_tlast,
  // out_tdata: [SAMPLE_BITS-1:0] window_max, rest zero padding
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]        out_tdata,
  output logic                                         out_tlast,
  // out_tuser: [0] incomplete
  output logic                                         out_tuser,
  // configuration: window_size
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [CFG_W-1:0]                        cfg_data
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned FILL_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned KW      = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int unsigned IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_accept;
  logic cfg_accept;
  logic out_valid_r;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign in_tready  = (!out_valid_r || out_tready) && !cfg_valid;
  assign in_accept  = in_tvalid && in_tready;

  logic [SAMPLE_BITS-1:0] sample;
  assign sample = in_tdata[SAMPLE_BITS-1:0];

  // --------------------------------------------------------------------------
  // Window size register and effective window length
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] window_size_r;
  logic [KW-1:0]    ws_ext;
  logic [KW-1:0]    eff_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(1);
    end else if (cfg_accept) begin
      window_size_r <= cfg_data;
    end
  end

  assign ws_ext = KW'(window_size_r);

  always_comb begin
    if (ws_ext == '0) begin
      eff_k = KW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      eff_k = KW'(WINDOW_MAX);
    end else begin
      eff_k = ws_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Fill counter: samples seen in this sequence, saturating at the window
  // --------------------------------------------------------------------------
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [KW-1:0]     fill_ext;
  logic              window_full;
  logic              fills_now;
  logic              emit;
  logic              incomplete;

  assign fill_ext    = KW'(fill_r);
  assign window_full = (fill_ext >= eff_k);
  assign fills_now   = !window_full && ((fill_ext + KW'(1)) == eff_k);
  assign emit        = window_full || fills_now || in_tlast;
  assign incomplete  = !window_full && !fills_now && in_tlast;

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_accept) begin
      fill_nxt = '0;
    end else if (in_accept) begin
      if (in_tlast) begin
        fill_nxt = '0;
      end else if (!window_full) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell i holds max of the last i+1 samples
  // --------------------------------------------------------------------------
  swm_ctrl_t              ctrl;
  logic [SAMPLE_BITS-1:0] cell_max   [WINDOW_MAX];
  logic                   cell_valid [WINDOW_MAX];

  assign ctrl = '{shift: in_accept && !cfg_accept,
                  clear: cfg_accept || (in_accept && in_tlast)};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      swm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample_i     (sample),
        .prev_max_i   (sample),
        .prev_valid_i (1'b0),
        .max_o        (cell_max[i]),
        .valid_o      (cell_valid[i])
      );
    end else begin : g_body
      swm_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sample_i     (sample),
        .prev_max_i   (cell_max[i-1]),
        .prev_valid_i (cell_valid[i-1]),
        .max_o        (cell_max[i]),
        .valid_o      (cell_valid[i])
      );
    end
  end

  // Result = max(sample, cell k-2); for a one-sample window it is the sample.
  // Before the fill point the cells hold the max of everything seen, so the
  // same tap serves the incomplete case.
  logic [IDX_W-1:0]       tap_idx;
  logic [SAMPLE_BITS-1:0] tap_max;
  logic                   tap_valid;
  logic [SAMPLE_BITS-1:0] result;
  logic [KW-1:0]          k_minus2;

  assign k_minus2  = eff_k - KW'(2);
  assign tap_idx   = k_minus2[IDX_W-1:0];
  assign tap_max   = cell_max[tap_idx];
  assign tap_valid = (eff_k > KW'(1)) && cell_valid[tap_idx];

  always_comb begin
    if (tap_valid && ($signed(tap_max) > $signed(sample))) begin
      result = tap_max;
    end else begin
      result = sample;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] out_max_r;
  logic                   out_last_r;
  logic                   out_inc_r;
  logic                   load_out;

  assign load_out = in_accept && !cfg_accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max_r  <= result;
      out_last_r <= in_tlast;
      out_inc_r  <= incomplete;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_max_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_inc_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_in_window : assert property (@(posedge clk) disable iff (!rst_n)
    fill_ext <= eff_k)
    else $error("fill count beyond window length");

  a_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=> (fill_r == '0))
    else $error("end of sequence did not clear fill count");

  a_end_emits : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast && !cfg_accept) |=> (out_valid_r && out_last_r))
    else $error("end of sequence produced no final result");

  a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> cell_valid[0])
    else $error("samples counted but head cell empty");

endmodule

`default_nettype wire
